FILE: rtl/smpq_pkg.sv
`default_nettype none

package smpq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int WEIGHT_BITS = 16;
    localparam int VERTEX_BITS = 8;
    localparam int COUNT_BITS  = $clog2(QUEUE_DEPTH + 1);

    localparam logic OP_INSERT  = 1'b0;
    localparam logic OP_EXTRACT = 1'b1;

    localparam logic [1:0] ST_INSERTED  = 2'd0;
    localparam logic [1:0] ST_EXTRACTED = 2'd1;
    localparam logic [1:0] ST_DROPPED   = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic                   opcode;
        logic [WEIGHT_BITS-1:0] new_weight;
        logic [VERTEX_BITS-1:0] new_source;
        logic [VERTEX_BITS-1:0] new_dest;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]             status;
        logic [WEIGHT_BITS-1:0] out_weight;
        logic [VERTEX_BITS-1:0] out_source;
        logic [VERTEX_BITS-1:0] out_dest;
        logic [WEIGHT_BITS-1:0] head_weight;
        logic [COUNT_BITS-1:0]  entry_total;
    } out_beat_t;

    typedef struct packed {
        logic [WEIGHT_BITS-1:0] weight;
        logic [VERTEX_BITS-1:0] source;
        logic [VERTEX_BITS-1:0] dest;
    } entry_t;

    // Broadcast to every cell in the cycle a beat is taken.
    typedef struct packed {
        logic ins;
        logic ext;
    } cell_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/sorted_min_priority_queue.sv
// Channel  Ports                       Beat
// -------  --------------------------  ----------------------------------------
// input    s_valid, s_ready, s_data    one insert or extract-min command
// result   m_valid, m_ready, m_data    status, extracted edge, head weight, count
//
// For every command, all cells compare the new weight in parallel and shift or load
// together at the accepting edge, so a beat can be taken each cycle while s_ready is high.
// The result register frees up in the same cycle it is read, so s_ready only
// drops while a result is held and m_ready is low.
// Reset empties the queue and the result register at once; the cells keep data.
`default_nettype none

module sorted_min_priority_queue (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire smpq_pkg::in_beat_t s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output smpq_pkg::out_beat_t     m_data
);

    localparam int DEPTH = smpq_pkg::QUEUE_DEPTH;
    localparam logic [smpq_pkg::COUNT_BITS-1:0] FULL_COUNT =
        smpq_pkg::COUNT_BITS'(DEPTH);

    logic [smpq_pkg::COUNT_BITS-1:0] count_reg;
    logic [smpq_pkg::COUNT_BITS-1:0] count_next;
    logic                            m_valid_reg;
    smpq_pkg::out_beat_t             m_data_reg;
    smpq_pkg::out_beat_t             m_data_next;

    logic                accept;
    logic                full;
    logic                empty;
    smpq_pkg::cell_ctl_t ctl;
    smpq_pkg::entry_t    new_entry;
    smpq_pkg::entry_t    cell_q [DEPTH];
    logic                heavier [DEPTH];

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign full    = count_reg == FULL_COUNT;
    assign empty   = count_reg == '0;

    assign new_entry.weight = s_data.new_weight;
    assign new_entry.source = s_data.new_source;
    assign new_entry.dest   = s_data.new_dest;

    assign ctl.ins = accept && (s_data.opcode == smpq_pkg::OP_INSERT) && !full;
    assign ctl.ext = accept && (s_data.opcode == smpq_pkg::OP_EXTRACT) && !empty;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        smpq_pkg::entry_t left_entry;
        smpq_pkg::entry_t right_entry;
        logic             left_heavier;

        if (i == 0) begin : g_first
            assign left_entry   = '0;
            assign left_heavier = 1'b0;
        end else begin : g_mid
            assign left_entry   = cell_q[i-1];
            assign left_heavier = heavier[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign right_entry = cell_q[i];
        end else begin : g_inner
            assign right_entry = cell_q[i+1];
        end

        smpq_cell #(
            .IDX(i)
        ) u_cell (
            .aclk        (aclk),
            .ctl         (ctl),
            .new_entry   (new_entry),
            .fill_count  (count_reg),
            .left_entry  (left_entry),
            .left_heavier(left_heavier),
            .right_entry (right_entry),
            .entry_q     (cell_q[i]),
            .heavier     (heavier[i])
        );
    end

    always_comb begin
        count_next              = count_reg;
        m_data_next             = '0;
        m_data_next.entry_total = count_reg;
        if (ctl.ins) begin
            count_next              = count_reg + 1'b1;
            m_data_next.status      = smpq_pkg::ST_INSERTED;
            m_data_next.entry_total = count_next;
            // Equal weights go behind the head, so the head only changes on a lighter edge.
            if (empty || (s_data.new_weight < cell_q[0].weight)) begin
                m_data_next.head_weight = s_data.new_weight;
            end else begin
                m_data_next.head_weight = cell_q[0].weight;
            end
        end else if (ctl.ext) begin
            count_next              = count_reg - 1'b1;
            m_data_next.status      = smpq_pkg::ST_EXTRACTED;
            m_data_next.entry_total = count_next;
            m_data_next.out_weight  = cell_q[0].weight;
            m_data_next.out_source  = cell_q[0].source;
            m_data_next.out_dest    = cell_q[0].dest;
            if (count_next != '0) begin
                m_data_next.head_weight = cell_q[1].weight;
            end
        end else if (s_data.opcode == smpq_pkg::OP_INSERT) begin
            m_data_next.status      = smpq_pkg::ST_DROPPED;
            m_data_next.head_weight = cell_q[0].weight;
        end else begin
            m_data_next.status = smpq_pkg::ST_EMPTY;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

FILE: rtl/smpq_cell.sv
`default_nettype none

module smpq_cell #(
    parameter int unsigned IDX = 0
) (
    input  wire logic                             aclk,
    input  wire smpq_pkg::cell_ctl_t              ctl,
    input  wire smpq_pkg::entry_t                 new_entry,
    input  wire logic [smpq_pkg::COUNT_BITS-1:0]  fill_count,
    input  wire smpq_pkg::entry_t                 left_entry,
    input  wire logic                             left_heavier,
    input  wire smpq_pkg::entry_t                 right_entry,
    output smpq_pkg::entry_t                      entry_q,
    output logic                                  heavier
);

    localparam logic [smpq_pkg::COUNT_BITS-1:0] IDX_C = smpq_pkg::COUNT_BITS'(IDX);

    smpq_pkg::entry_t entry_reg;
    smpq_pkg::entry_t entry_next;
    logic             occupied;

    assign occupied = IDX_C < fill_count;
    assign heavier  = occupied && (entry_reg.weight > new_entry.weight);
    assign entry_q  = entry_reg;

    // The queue is sorted, so a heavier left neighbor means this cell is heavier too
    // and the row shifts right from the insertion point on.
    always_comb begin
        entry_next = entry_reg;
        if (ctl.ext) begin
            entry_next = right_entry;
        end else if (ctl.ins) begin
            if (left_heavier) begin
                entry_next = left_entry;
            end else if (heavier || !occupied) begin
                entry_next = new_entry;
            end
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

FILE: rtl/smpq_checker.sv
`default_nettype none

module smpq_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire smpq_pkg::in_beat_t  s_data,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire smpq_pkg::out_beat_t m_data
);

    localparam logic [smpq_pkg::COUNT_BITS-1:0] FULL_COUNT =
        smpq_pkg::COUNT_BITS'(smpq_pkg::QUEUE_DEPTH);

    // A result that is not taken stays on the port unchanged.
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // The reported count agrees with the outcome of the command.
    a_status_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_data.status == smpq_pkg::ST_EMPTY && m_data.entry_total == '0)
                  || (m_data.status == smpq_pkg::ST_DROPPED
                      && m_data.entry_total == FULL_COUNT)
                  || (m_data.status == smpq_pkg::ST_INSERTED
                      && m_data.entry_total != '0)
                  || (m_data.status == smpq_pkg::ST_EXTRACTED
                      && m_data.entry_total != FULL_COUNT)))
        else $error("status and entry count disagree");

    // The extracted edge is never heavier than what is left at the head.
    a_min_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == smpq_pkg::ST_EXTRACTED && m_data.entry_total != '0
        |-> m_data.out_weight <= m_data.head_weight)
        else $error("extracted edge heavier than the new head");

    // No result may appear in the cycle after reset.
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind sorted_min_priority_queue smpq_checker u_smpq_checker (.*);

`default_nettype wire
